@@ src/slcr_pkg.sv @@
// Package for the serial link controller register core.
// Holds transfer payload types, the sequencer state type and window offsets.
// No dependencies.
package slcr_pkg;

  localparam int unsigned WINDOW_WORDS_DEF = 16384;
  localparam int unsigned PHY_DEPTH        = 16;
  localparam int unsigned PHY_IDX_W        = 4;

  localparam logic [15:0] OFS_NODE_ID   = 16'h8400;
  localparam logic [15:0] OFS_CTRL0     = 16'h8408;
  localparam logic [15:0] OFS_CTRL2     = 16'h8410;
  localparam logic [15:0] OFS_PHY       = 16'h8414;
  localparam logic [15:0] OFS_INT0      = 16'h8420;
  localparam logic [15:0] OFS_INT0_MASK = 16'h8424;
  localparam logic [15:0] OFS_INT1      = 16'h8428;
  localparam logic [15:0] OFS_INT2      = 16'h8430;
  localparam logic [15:0] OFS_LINK_ID   = 16'h847c;

  localparam logic [31:0] NODE_ID_WORD  = 32'hffc0_0001;
  localparam logic [31:0] LINK_ID_WORD  = 32'h1000_0001;
  localparam logic [31:0] PHY_WR_CLEAR  = 32'h4000_ffff;
  localparam logic [31:0] PHY_RD_FLAG   = 32'h8000_0000;
  localparam logic [31:0] PHY_WR_FLAG   = 32'h4000_0000;
  localparam logic [31:0] RX_IRQ_BIT    = 32'h4000_0000;
  localparam logic [31:0] CTRL0_DROP    = 32'h0080_0000;
  localparam logic [31:0] CTRL2_VALUE   = 32'h0000_0008;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] offset;
    logic [31:0] write_data;
  } slcr_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_pulse;
  } slcr_out_t;

  typedef struct packed {
    logic                 en;
    logic [PHY_IDX_W-1:0] idx;
    logic [7:0]           data;
  } slcr_phy_wr_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_AUX
  } slcr_state_t;

endpackage

@@ src/slcr_phy_bank.sv @@
// Bank of sixteen 8-bit PHY registers, cleared on reset.
// One write port, one combinational read port. Depends on slcr_pkg.
module slcr_phy_bank (
  input  logic                                clk,
  input  logic                                rst_n,
  input  slcr_pkg::slcr_phy_wr_t              wr,
  input  logic [slcr_pkg::PHY_IDX_W-1:0]      rd_idx,
  output logic [7:0]                          rd_data
);
  import slcr_pkg::*;

  logic [7:0] bank_r [PHY_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PHY_DEPTH; i++) begin
        bank_r[i] <= '0;
      end
    end else if (wr.en) begin
      bank_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data = bank_r[rd_idx];

endmodule

@@ src/serial_link_controller_registers_core.sv @@
// Top level of the serial link controller register core.
// Word store memory with read-modify-write sequencer; uses slcr_pkg, slcr_phy_bank.
//
//   channel | ports                     | payload
//   input   | in_valid, in_ready        | in_data  (slcr_in_t)
//   result  | out_valid, out_ready      | out_data (slcr_out_t)
//
// An access is accepted with a store read, then executed, with a store write for a write access.
// A PHY read command that raises the receive interrupt adds the ST_AUX state after execute:
// the interrupt word is written back there over the single store write port.
// After reset the store is cleared one word a cycle, all WINDOW_WORDS words, with in_ready low.
// A stalled result holds the execute cycle; one result waits in the output register.
module serial_link_controller_registers_core #(
  parameter int unsigned WINDOW_WORDS = slcr_pkg::WINDOW_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slcr_pkg::slcr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output slcr_pkg::slcr_out_t out_data
);
  import slcr_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_WORDS);

  slcr_state_t state_r, state_nxt;

  logic [31:0]   mem [WINDOW_WORDS];
  logic [31:0]   mem_rdata_r;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_done;

  slcr_in_t      item_r;
  logic          mask_r, mask_nxt;
  logic          out_valid_r, out_valid_nxt;
  slcr_out_t     out_data_r, out_data_nxt;

  logic          accept;
  logic          exec_go;
  logic          in_phy_irq;
  logic          it_phy;
  logic          it_phy_wr;
  logic          it_phy_rd;
  logic          it_phy_irq;
  logic [AW-1:0] it_addr;
  logic [PHY_IDX_W-1:0] phy_rd_idx;
  logic [7:0]    phy_rd_data;
  slcr_phy_wr_t  phy_wr;
  logic [31:0]   phy_rd_word;

  slcr_phy_bank u_phy (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (phy_wr),
    .rd_idx  (phy_rd_idx),
    .rd_data (phy_rd_data)
  );

  assign accept    = in_valid && in_ready;
  assign exec_go   = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign clr_done  = (clr_cnt_r == AW'(WINDOW_WORDS - 1));

  assign in_phy_irq = (in_data.action == ACT_WRITE) && (in_data.offset[15:2] == OFS_PHY[15:2])
                      && !in_data.write_data[30] && in_data.write_data[31] && mask_r;

  assign it_addr    = item_r.offset[AW+1:2];
  assign it_phy     = (item_r.action == ACT_WRITE) && (item_r.offset[15:2] == OFS_PHY[15:2]);
  assign it_phy_wr  = it_phy && item_r.write_data[30];
  assign it_phy_rd  = it_phy && !item_r.write_data[30] && item_r.write_data[31];
  assign it_phy_irq = it_phy_rd && mask_r;

  assign phy_rd_idx  = item_r.write_data[27:24];
  assign phy_rd_word = (item_r.write_data & ~PHY_RD_FLAG) | {24'd0, phy_rd_data}
                       | {20'd0, phy_rd_idx, 8'd0};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_EXEC;
      ST_EXEC:  if (exec_go) state_nxt = it_phy_irq ? ST_AUX : ST_IDLE;
      ST_AUX:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    clr_cnt_nxt   = clr_cnt_r;
    mem_re        = 1'b0;
    mem_raddr     = in_data.offset[AW+1:2];
    mem_we        = 1'b0;
    mem_waddr     = it_addr;
    mem_wdata     = item_r.write_data;
    mask_nxt      = mask_r;
    phy_wr        = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        mem_re = accept;
        if (in_phy_irq) begin
          mem_raddr = OFS_INT0[AW+1:2];
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.read_data = '0;
          out_data_nxt.irq_pulse = it_phy_irq;
          if (item_r.action == ACT_READ) begin
            priority if (item_r.offset[15:2] == OFS_NODE_ID[15:2]) begin
              out_data_nxt.read_data = NODE_ID_WORD;
            end else if (item_r.offset[15:2] == OFS_LINK_ID[15:2]) begin
              out_data_nxt.read_data = LINK_ID_WORD;
            end else begin
              out_data_nxt.read_data = mem_rdata_r;
            end
          end else begin
            mem_we = 1'b1;
            priority if (it_phy_wr) begin
              mem_wdata   = item_r.write_data & ~PHY_WR_CLEAR;
              phy_wr.en   = 1'b1;
              phy_wr.idx  = item_r.write_data[11:8];
              phy_wr.data = item_r.write_data[7:0];
            end else if (it_phy_rd) begin
              mem_wdata = phy_rd_word;
            end else if (it_phy) begin
              mem_wdata = item_r.write_data;
            end else if (item_r.offset[15:2] == OFS_CTRL0[15:2]) begin
              mem_wdata = item_r.write_data & ~CTRL0_DROP;
            end else if (item_r.offset[15:2] == OFS_CTRL2[15:2]) begin
              mem_wdata = CTRL2_VALUE;
            end else if (item_r.offset[15:2] == OFS_INT0[15:2]
                         || item_r.offset[15:2] == OFS_INT1[15:2]
                         || item_r.offset[15:2] == OFS_INT2[15:2]) begin
              mem_wdata = mem_rdata_r & ~item_r.write_data;
            end else begin
              mem_wdata = item_r.write_data;
            end
            if (item_r.offset[15:2] == OFS_INT0_MASK[15:2]) begin
              mask_nxt = item_r.write_data[30];
            end
          end
        end
      end
      ST_AUX: begin
        mem_we    = 1'b1;
        mem_waddr = OFS_INT0[AW+1:2];
        mem_wdata = mem_rdata_r | RX_IRQ_BIT;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      mask_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/slcr_checker.sv @@
// Port-level checker for the serial link controller register core.
// Bound to serial_link_controller_registers_core; depends on slcr_pkg.
module slcr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input slcr_pkg::slcr_out_t out_data
);
  import slcr_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_irq_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.irq_pulse |-> out_data.read_data == 32'd0)
    else $error("interrupt pulse with nonzero read data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("second transfer taken while busy");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after transfer");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or valid high right after reset");

endmodule

bind serial_link_controller_registers_core slcr_checker u_slcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for serial_link_controller_registers_core.
// Predicts every bus access against its own register window and PHY bank model;
// depends on slcr_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import slcr_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int STALL_LIMIT  = 60000;
  localparam int LONG_HOLDOFF = 400;
  localparam int DRAIN_CYCLES = 12;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  slcr_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  slcr_out_t out_data;

  logic [31:0] link_words [WINDOW_WORDS_DEF];
  logic [7:0]  phy_bytes  [PHY_DEPTH];

  slcr_in_t  access_queue[$];
  slcr_out_t expected_replies[$];

  int send_idle_pct = 16;
  int recv_idle_pct = 78;
  int error_count   = 0;
  int queued_total  = 0;
  int idle_cycles   = 0;
  int holdoff_count = 0;
  bit holdoff_armed = 1'b0;

  wire in_fire  = in_valid && in_ready;
  wire out_fire = out_valid && out_ready;

  serial_link_controller_registers_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic slcr_out_t apply_bus_access(slcr_in_t acc);
    logic [15:0] ofs;
    logic [13:0] wi;
    logic [31:0] v;
    logic [31:0] w;
    logic [3:0]  idx;
    slcr_out_t   res;
    ofs = {acc.offset[15:2], 2'b00};
    wi  = ofs[15:2];
    v   = acc.write_data;
    res = '0;
    if (acc.action == ACT_READ) begin
      if (ofs == OFS_NODE_ID) res.read_data = NODE_ID_WORD;
      else if (ofs == OFS_LINK_ID) res.read_data = LINK_ID_WORD;
      else res.read_data = link_words[wi];
    end else begin
      case (ofs)
        OFS_PHY: begin
          link_words[wi] = v;
          if ((v & PHY_WR_FLAG) != 0) begin
            idx = v[11:8];
            phy_bytes[idx] = v[7:0];
            link_words[wi] = v & ~PHY_WR_CLEAR;
          end else if ((v & PHY_RD_FLAG) != 0) begin
            idx = v[27:24];
            w = (v & ~PHY_RD_FLAG) | {24'h0, phy_bytes[idx]} | {20'h0, idx, 8'h0};
            link_words[wi] = w;
            if ((link_words[OFS_INT0_MASK[15:2]] & RX_IRQ_BIT) != 0) begin
              link_words[OFS_INT0[15:2]] = link_words[OFS_INT0[15:2]] | RX_IRQ_BIT;
              res.irq_pulse = 1'b1;
            end
          end
        end
        OFS_CTRL0: link_words[wi] = v & ~CTRL0_DROP;
        OFS_CTRL2: link_words[wi] = CTRL2_VALUE;
        OFS_INT0, OFS_INT1, OFS_INT2: link_words[wi] = link_words[wi] & ~v;
        default: link_words[wi] = v;
      endcase
    end
    return res;
  endfunction

  task automatic queue_access(logic act, logic [15:0] ofs, logic [31:0] data);
    slcr_in_t acc;
    acc.action     = act;
    acc.offset     = ofs;
    acc.write_data = data;
    access_queue.push_back(acc);
    queued_total++;
  endtask

  function automatic logic [15:0] jitter(logic [15:0] ofs);
    return ($urandom_range(3) == 0) ? {ofs[15:2], 2'($urandom)} : ofs;
  endfunction

  function automatic logic [15:0] pick_special_offset();
    case ($urandom_range(9))
      0: return OFS_NODE_ID;
      1: return OFS_CTRL0;
      2: return OFS_CTRL2;
      3: return OFS_PHY;
      4: return OFS_INT0;
      5: return OFS_INT0_MASK;
      6: return OFS_INT1;
      7: return OFS_INT2;
      8: return OFS_LINK_ID;
      default: return 16'h8404;
    endcase
  endfunction

  task automatic queue_random_traffic(int count);
    int          target;
    int          pick;
    int          k;
    logic [3:0]  idx;
    logic [31:0] d;
    logic [15:0] ofs;
    target = queued_total + count;
    while (queued_total < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // PHY round trip: store a byte, fetch it (or another index) back, check the interrupt path
        idx = 4'($urandom);
        if ($urandom_range(2) == 0) queue_access(ACT_WRITE, jitter(OFS_INT0_MASK), $urandom);
        d = $urandom;
        d[30] = 1'b1;
        d[11:8] = idx;
        queue_access(ACT_WRITE, jitter(OFS_PHY), d);
        d = $urandom;
        d[31] = 1'b1;
        d[30] = 1'b0;
        d[27:24] = ($urandom_range(4) == 0) ? 4'($urandom) : idx;
        queue_access(ACT_WRITE, jitter(OFS_PHY), d);
        queue_access(ACT_READ, jitter(OFS_PHY), $urandom);
        queue_access(ACT_READ, jitter(OFS_INT0), $urandom);
        if ($urandom_range(1) == 0) begin
          d = ($urandom_range(1) == 0) ? RX_IRQ_BIT : $urandom;
          queue_access(ACT_WRITE, jitter(OFS_INT0), d);
        end
      end else if (pick < 72) begin
        queue_access(1'($urandom), jitter(pick_special_offset()), $urandom);
      end else if (pick < 92) begin
        k = $urandom_range(7);
        ofs = (k < 4) ? 16'(k * 4) : 16'(16'hfff0 + (k - 4) * 4);
        queue_access(1'($urandom), jitter(ofs), $urandom);
      end else begin
        queue_access(1'($urandom), 16'($urandom), $urandom);
      end
    end
  endtask

  task automatic wait_drained();
    while (access_queue.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_replies.push_back(apply_bus_access(in_data));
      if (access_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= access_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holdoff_armed && holdoff_count < LONG_HOLDOFF) begin
      out_ready     <= 1'b0;
      holdoff_count <= holdoff_count + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    slcr_out_t want;
    if (rst_n && out_fire) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected transfer, actual %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_data.read_data !== want.read_data) begin
          $display("%0t: read_data mismatch, expected %h actual %h",
                   $time, want.read_data, out_data.read_data);
          error_count++;
        end
        if (out_data.irq_pulse !== want.irq_pulse) begin
          $display("%0t: irq_pulse mismatch, expected %b actual %b",
                   $time, want.irq_pulse, out_data.irq_pulse);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < WINDOW_WORDS_DEF; i++) link_words[i] = '0;
    for (int i = 0; i < PHY_DEPTH; i++) phy_bytes[i] = '0;

    queue_access(ACT_READ,  OFS_CTRL2,     32'h0);
    queue_access(ACT_WRITE, OFS_CTRL2,     32'hffff_ffff);
    queue_access(ACT_READ,  OFS_CTRL2,     32'hffff_ffff);
    queue_access(ACT_WRITE, OFS_CTRL0,     32'hffff_ffff);
    queue_access(ACT_READ,  OFS_CTRL0,     32'h0);
    queue_access(ACT_WRITE, OFS_NODE_ID,   32'h1234_5678);
    queue_access(ACT_READ,  OFS_NODE_ID,   32'h0);
    queue_access(ACT_READ,  OFS_LINK_ID,   32'h0);
    queue_access(ACT_WRITE, OFS_PHY,       32'hffff_ffff);
    queue_access(ACT_READ,  OFS_PHY,       32'h0);
    queue_access(ACT_WRITE, OFS_PHY,       32'h8f00_0000);
    queue_access(ACT_READ,  OFS_PHY,       32'h0);
    queue_access(ACT_WRITE, OFS_INT0_MASK, RX_IRQ_BIT);
    queue_access(ACT_WRITE, OFS_PHY,       32'h8000_0000);
    queue_access(ACT_READ,  OFS_INT0,      32'h0);
    queue_access(ACT_WRITE, OFS_INT0,      32'h0);
    queue_access(ACT_READ,  OFS_INT0,      32'h0);
    queue_access(ACT_WRITE, OFS_INT0,      32'hffff_ffff);
    queue_access(ACT_READ,  OFS_INT0,      32'h0);
    queue_access(ACT_WRITE, OFS_INT1,      32'hffff_ffff);
    queue_access(ACT_READ,  OFS_INT2,      32'h0);
    queue_access(ACT_WRITE, OFS_PHY | 16'h3, 32'h4000_0312);
    queue_access(ACT_WRITE, 16'hffff,      32'hffff_ffff);
    queue_access(ACT_READ,  16'hfffc,      32'h0);
    queue_access(ACT_READ,  16'h0003,      32'h0);
    queue_random_traffic(400);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    @(negedge clk);
    send_idle_pct = 78;
    recv_idle_pct = 16;
    queue_random_traffic(420);
    wait_drained();

    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holdoff_armed = 1'b1;
    queue_random_traffic(420);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/slcr_pkg.sv
src/slcr_phy_bank.sv
src/serial_link_controller_registers_core.sv
src/slcr_checker.sv
tb/sv/testbench.sv
